/* design/assert_macros.svh */
// Assertion helpers shared by the rotator RTL.
// Every user module clocks on clk_i and resets on the active-low rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* design/qtr_pkg.sv */
`default_nettype none

package qtr_pkg;

  localparam int DIM_W      = 9;
  localparam int SEL_W      = 8;
  localparam int TURN_W     = 2;
  localparam int PIX_W      = 24;
  localparam int STATUS_W   = 2;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SEL_LEFT      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEL_TOP       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SEL_RIGHT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SEL_BOTTOM    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_QUARTER_TURNS = 3'd6;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_READ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SEL_BAD    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd2;

  localparam logic [TURN_W-1:0] TURN_NONE = 2'd0;
  localparam logic [TURN_W-1:0] TURN_CW90 = 2'd1;
  localparam logic [TURN_W-1:0] TURN_HALF = 2'd2;
  localparam logic [TURN_W-1:0] TURN_CCW90 = 2'd3;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel_out;
    logic                out_last;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Live configuration with the derived selection checks.
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [SEL_W-1:0]  sel_left;
    logic [SEL_W-1:0]  sel_top;
    logic [DIM_W-1:0]  sel_right;
    logic [DIM_W-1:0]  sel_bottom;
    logic [TURN_W-1:0] turns;
    logic              full;
    logic              sel_bad;
    logic [DIM_W-1:0]  res_width;
    logic [DIM_W-1:0]  sel_size;
  } cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_dim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > max_dim) begin
      r = DIM_W'(max_dim);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/qtr_ram.sv */
`default_nettype none

module qtr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* design/qtr_divider.sv */
`default_nettype none

`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
module qtr_divider #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 9
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o,
  output logic      [DEN_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_d   = {quo_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  `ASSERT_RST(a_rem_below_den, done_q |-> (rem_q < den_q), "divider remainder not reduced")
  `ASSERT_RST(a_done_after_busy, done_q |-> $past(busy_q), "divider done without a run")

endmodule

`default_nettype wire

/* design/qtr_cfg_regs.sv */
`default_nettype none

module qtr_cfg_regs #(
  parameter int MAX_DIM = 256,
  parameter int TOT_W   = 17
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel_i,
  input  wire logic                             penable_i,
  input  wire logic                             pwrite_i,
  input  wire logic [qtr_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  wire logic [qtr_pkg::APB_DATA_W-1:0]   pwdata_i,
  output logic      [qtr_pkg::APB_DATA_W-1:0]   prdata_o,
  output logic                                  pready_o,
  output qtr_pkg::cfg_t                         cfg_o,
  output logic      [TOT_W-1:0]                 total_o,
  output logic                                  wr_o
);

  localparam logic [qtr_pkg::DIM_W-1:0] RAW_RST = qtr_pkg::DIM_W'(256);
  localparam logic [qtr_pkg::DIM_W-1:0] DIM_RST = qtr_pkg::clamp_dim(RAW_RST, MAX_DIM);
  localparam int TOT_RST = int'(DIM_RST) * int'(DIM_RST);

  logic [qtr_pkg::DIM_W-1:0]     fw_q, fh_q;
  logic [qtr_pkg::DIM_W-1:0]     w_q, h_q;
  logic [TOT_W-1:0]              total_q;
  logic [qtr_pkg::SEL_W-1:0]     sel_left_q, sel_top_q;
  logic [qtr_pkg::DIM_W-1:0]     sel_right_q, sel_bottom_q;
  logic [qtr_pkg::TURN_W-1:0]    turns_q;

  logic [qtr_pkg::REG_IDX_W-1:0] idx;
  logic                          wr_en;
  logic [qtr_pkg::DIM_W-1:0]     new_dim;
  logic [2*qtr_pkg::DIM_W-1:0]   prod_w, prod_h;
  logic [qtr_pkg::DIM_W-1:0]     n_cols, n_rows;
  logic                          full;

  assign idx      = paddr_i[qtr_pkg::APB_ADDR_W-1:2];
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign wr_o     = wr_en;

  // The frame size product is kept up to date at each size write.
  always_comb begin
    new_dim = qtr_pkg::clamp_dim(pwdata_i[qtr_pkg::DIM_W-1:0], MAX_DIM);
    prod_w  = new_dim * h_q;
    prod_h  = w_q * new_dim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q         <= RAW_RST;
      fh_q         <= RAW_RST;
      w_q          <= DIM_RST;
      h_q          <= DIM_RST;
      total_q      <= TOT_W'(TOT_RST);
      sel_left_q   <= '0;
      sel_top_q    <= '0;
      sel_right_q  <= RAW_RST;
      sel_bottom_q <= RAW_RST;
      turns_q      <= qtr_pkg::TURN_NONE;
    end else if (wr_en) begin
      unique case (idx)
        qtr_pkg::REG_FRAME_WIDTH: begin
          fw_q    <= pwdata_i[qtr_pkg::DIM_W-1:0];
          w_q     <= new_dim;
          total_q <= TOT_W'(prod_w);
        end
        qtr_pkg::REG_FRAME_HEIGHT: begin
          fh_q    <= pwdata_i[qtr_pkg::DIM_W-1:0];
          h_q     <= new_dim;
          total_q <= TOT_W'(prod_h);
        end
        qtr_pkg::REG_SEL_LEFT:      sel_left_q   <= pwdata_i[qtr_pkg::SEL_W-1:0];
        qtr_pkg::REG_SEL_TOP:       sel_top_q    <= pwdata_i[qtr_pkg::SEL_W-1:0];
        qtr_pkg::REG_SEL_RIGHT:     sel_right_q  <= pwdata_i[qtr_pkg::DIM_W-1:0];
        qtr_pkg::REG_SEL_BOTTOM:    sel_bottom_q <= pwdata_i[qtr_pkg::DIM_W-1:0];
        qtr_pkg::REG_QUARTER_TURNS: turns_q      <= pwdata_i[qtr_pkg::TURN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qtr_pkg::REG_FRAME_WIDTH:   prdata_o = qtr_pkg::APB_DATA_W'(fw_q);
      qtr_pkg::REG_FRAME_HEIGHT:  prdata_o = qtr_pkg::APB_DATA_W'(fh_q);
      qtr_pkg::REG_SEL_LEFT:      prdata_o = qtr_pkg::APB_DATA_W'(sel_left_q);
      qtr_pkg::REG_SEL_TOP:       prdata_o = qtr_pkg::APB_DATA_W'(sel_top_q);
      qtr_pkg::REG_SEL_RIGHT:     prdata_o = qtr_pkg::APB_DATA_W'(sel_right_q);
      qtr_pkg::REG_SEL_BOTTOM:    prdata_o = qtr_pkg::APB_DATA_W'(sel_bottom_q);
      qtr_pkg::REG_QUARTER_TURNS: prdata_o = qtr_pkg::APB_DATA_W'(turns_q);
      default:                    prdata_o = '0;
    endcase
  end

  // A selection that is not the whole frame must be a non-empty square inside it.
  always_comb begin
    full   = (sel_left_q == '0) && (sel_top_q == '0) &&
             (sel_right_q == w_q) && (sel_bottom_q == h_q);
    n_cols = sel_right_q - {1'b0, sel_left_q};
    n_rows = sel_bottom_q - {1'b0, sel_top_q};

    cfg_o.width      = w_q;
    cfg_o.height     = h_q;
    cfg_o.sel_left   = sel_left_q;
    cfg_o.sel_top    = sel_top_q;
    cfg_o.sel_right  = sel_right_q;
    cfg_o.sel_bottom = sel_bottom_q;
    cfg_o.turns      = turns_q;
    cfg_o.full       = full;
    cfg_o.sel_bad    = !full && ((sel_right_q <= {1'b0, sel_left_q}) ||
                                 (sel_bottom_q <= {1'b0, sel_top_q}) ||
                                 (sel_right_q > w_q) || (sel_bottom_q > h_q) ||
                                 (n_cols != n_rows));
    cfg_o.res_width  = (full && turns_q[0]) ? h_q : w_q;
    cfg_o.sel_size   = n_cols;
  end

  assign total_o = total_q;

endmodule

`default_nettype wire

/* design/quarter_turn_image_rotator_top.sv */
// Quarter-turn image rotator. Load beats (action 0) write one pixel each into the frame
// store in raster order and are taken every cycle while idle; they return nothing. Once
// frame_width by frame_height pixels are in, each read beat (action 1) returns the next
// pixel of the frame turned clockwise by quarter_turns, in raster order of the result
// frame, with out_last on its final pixel. A selection that covers the whole frame turns
// the whole image (width and height swap on odd turn counts); otherwise only the square
// selection turns in place. A read beat answers status 1 for a bad selection and status 2
// while the loaded frame does not match the programmed size, with no store access. A good
// read passes through the map, address and data states before the next beat is taken: the
// source row and column are mapped, the store address is formed with one multiply, and the
// store is read through its single registered read port. The block keeps the result column
// and row as counters; after any register write the first good read rebuilds them with a
// one bit per cycle divider, unless a frame restart or a wrap cleared them. The store needs
// no clearing pass after reset, since an entry is read only after it has been written.
// Registers sit at byte address 4*index on the APB port; the user must write them only
// while the block is idle, which the block does not enforce. pready is always high.
`default_nettype none

`include "assert_macros.svh"

module quarter_turn_image_rotator_top #(
  parameter int MAX_DIM = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire qtr_pkg::in_item_t                in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output qtr_pkg::out_item_t                    out_data_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [qtr_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [qtr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [qtr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);

  // Pixel positions count up to the full frame size; the store holds MAX_DIM squared.
  localparam int PW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int DW = qtr_pkg::DIM_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MAP  = 5'b00100,
    S_ADDR = 5'b01000,
    S_DATA = 5'b10000
  } state_e;

  state_e state_q, state_d;

  qtr_pkg::cfg_t cfg;
  logic [PW-1:0] total;
  logic          cfg_wr;

  logic [PW-1:0] load_pos_q, load_pos_d;
  logic          loaded_q, loaded_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [DW-1:0] x_q, x_d, y_q, y_d;
  logic          stale_q, stale_d;
  logic          out_valid_q, out_valid_d;
  qtr_pkg::out_item_t out_q, out_d;
  logic [DW-1:0] sr_q, sc_q;
  logic [DW-1:0] sr, sc;

  logic          out_free, is_read, in_acc;
  logic          err_nl, err_sel, restart;
  logic [PW-1:0] wr_pos, load_next, total_m1;
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [qtr_pkg::PIX_W-1:0] ram_rdata;
  logic [2*DW-1:0] addr_prod;

  logic          div_start, div_done;
  logic [PW-1:0] div_quo;
  logic [DW-1:0] div_rem;

  qtr_cfg_regs #(
    .MAX_DIM (MAX_DIM),
    .TOT_W   (PW)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg),
    .total_o   (total),
    .wr_o      (cfg_wr)
  );

  // Rebuilds the result column and row from the linear read position.
  qtr_divider #(
    .NUM_W (PW),
    .DEN_W (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (pos_q),
    .den_i   (cfg.res_width),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // Writes happen only in the idle state and reads only in the address state, so the
  // store never sees a write and a read of the same entry in flight together.
  qtr_ram #(
    .WIDTH (qtr_pkg::PIX_W),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (AW'(wr_pos)),
    .wr_data_i (in_data_i.pixel_in),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rdata)
  );

  // A new frame starts when the previous one completed or the size shrank under it.
  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    is_read    = in_data_i.action == qtr_pkg::ACTION_READ;
    in_ready_o = (state_q == S_IDLE) && (!is_read || out_free);
    in_acc     = in_valid_i && in_ready_o;
    err_nl     = !loaded_q || (load_pos_q != total);
    err_sel    = cfg.sel_bad;
    restart    = loaded_q || (load_pos_q >= total);
    wr_pos     = restart ? '0 : load_pos_q;
    load_next  = wr_pos + PW'(1);
    total_m1   = total - PW'(1);
    ram_wr_en  = in_acc && !is_read;
  end

  // Source pixel of result position (x_q, y_q).
  always_comb begin
    logic [DW-1:0] wm1, hm1, nm1, ly, lx, ty, tx;
    logic          in_sel;
    wm1    = cfg.width - DW'(1);
    hm1    = cfg.height - DW'(1);
    nm1    = cfg.sel_size - DW'(1);
    ly     = y_q - {1'b0, cfg.sel_top};
    lx     = x_q - {1'b0, cfg.sel_left};
    in_sel = (y_q >= {1'b0, cfg.sel_top}) && (y_q < cfg.sel_bottom) &&
             (x_q >= {1'b0, cfg.sel_left}) && (x_q < cfg.sel_right);
    sr     = y_q;
    sc     = x_q;
    ty     = ly;
    tx     = lx;
    if (cfg.full) begin
      case (cfg.turns)
        qtr_pkg::TURN_CW90: begin
          sr = hm1 - x_q;
          sc = y_q;
        end
        qtr_pkg::TURN_HALF: begin
          sr = hm1 - y_q;
          sc = wm1 - x_q;
        end
        qtr_pkg::TURN_CCW90: begin
          sr = x_q;
          sc = wm1 - y_q;
        end
        default: begin
        end
      endcase
    end else if (in_sel) begin
      case (cfg.turns)
        qtr_pkg::TURN_CW90: begin
          ty = nm1 - lx;
          tx = ly;
        end
        qtr_pkg::TURN_HALF: begin
          ty = nm1 - ly;
          tx = nm1 - lx;
        end
        qtr_pkg::TURN_CCW90: begin
          ty = lx;
          tx = nm1 - ly;
        end
        default: begin
        end
      endcase
      sr = {1'b0, cfg.sel_top} + ty;
      sc = {1'b0, cfg.sel_left} + tx;
    end
  end

  // Raster address of the mapped source pixel, fed straight into the store's read port.
  always_comb begin
    addr_prod   = sr_q * cfg.width;
    ram_rd_addr = AW'(addr_prod + (2*DW)'(sc_q));
  end

  always_comb begin
    state_d     = state_q;
    load_pos_d  = load_pos_q;
    loaded_d    = loaded_q;
    pos_d       = pos_q;
    x_d         = x_q;
    y_d         = y_q;
    stale_d     = stale_q || cfg_wr;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    div_start   = 1'b0;
    ram_rd_en   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!is_read) begin
            load_pos_d = load_next;
            loaded_d   = load_next == total;
            if (restart) begin
              pos_d   = '0;
              x_d     = '0;
              y_d     = '0;
              stale_d = 1'b0;
            end
          end else if (err_nl || err_sel) begin
            // Errors answer at once and leave the read position alone.
            out_valid_d     = 1'b1;
            out_d.pixel_out = '0;
            out_d.out_last  = 1'b0;
            out_d.status    = err_nl ? qtr_pkg::STATUS_NOT_LOADED : qtr_pkg::STATUS_SEL_BAD;
          end else if (pos_q >= total) begin
            pos_d   = '0;
            x_d     = '0;
            y_d     = '0;
            stale_d = 1'b0;
            state_d = S_MAP;
          end else if (stale_q) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else begin
            state_d = S_MAP;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          x_d     = div_rem;
          y_d     = DW'(div_quo);
          stale_d = 1'b0;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        state_d = S_ADDR;
      end
      S_ADDR: begin
        ram_rd_en = 1'b1;
        state_d   = S_DATA;
      end
      S_DATA: begin
        // The store holds its read data while the output register is still full.
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.pixel_out = ram_rdata;
          out_d.out_last  = pos_q == total_m1;
          out_d.status    = qtr_pkg::STATUS_OK;
          if (pos_q == total_m1) begin
            pos_d = '0;
            x_d   = '0;
            y_d   = '0;
          end else begin
            pos_d = pos_q + PW'(1);
            if (x_q + DW'(1) == cfg.res_width) begin
              x_d = '0;
              y_d = y_q + DW'(1);
            end else begin
              x_d = x_q + DW'(1);
            end
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_pos_q  <= '0;
      loaded_q    <= 1'b0;
      pos_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      stale_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_pos_q  <= load_pos_d;
      loaded_q    <= loaded_d;
      pos_q       <= pos_d;
      x_q         <= x_d;
      y_q         <= y_d;
      stale_q     <= stale_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (state_q == S_MAP) begin
      sr_q <= sr;
      sc_q <= sc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ON(a_store_one_access, !(ram_wr_en && ram_rd_en), "store written and read together")
  `ASSERT_RST(a_data_delivered, (state_q == S_DATA && out_free) |=> out_valid_q,
              "fetched pixel not placed in the output register")
  `ASSERT_RST(a_good_read_busy, (in_acc && is_read && !err_nl && !err_sel) |=> (state_q != S_IDLE),
              "good read beat did not start a fetch")

endmodule

`default_nettype wire

/* verif/quarter_turn_image_rotator_top_test.sv */
`default_nettype none

// Testbench for the quarter-turn image rotator.
//
// Input beats are queued by the stimulus process and presented by a clocked driver. Every
// accepted beat runs through a local model of the rotator (frame store copy, load and
// read positions, register mirror), and each read beat leaves one expected result in
// a queue. A clocked monitor pops that queue on every accepted result beat and compares
// pixel, last flag and status. Registers are only reprogrammed once the block has gone
// quiet, which also gives the sender its pause until every result has come back.
module quarter_turn_image_rotator_top_test;

  import qtr_pkg::*;

  localparam int MAX_DIM = 256;
  // Quiet time before a register write and at the end of the run. It covers the good-read
  // latency plus the divider rebuild after a write, with margin.
  localparam int SETTLE_CYCLES = 40;
  localparam int TIMEOUT_CYCLES = 400000;
  // The directed part queues 25 beats and the random part about 850 more.
  localparam int TOTAL_BEATS = 875;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Input channel.
  logic     beat_valid = 1'b0;
  in_item_t beat_data = '0;
  logic     in_ready;

  // Result channel.
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result_data;

  // Register port.
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  quarter_turn_image_rotator_top #(
    .MAX_DIM(MAX_DIM)
  ) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(beat_valid),
    .in_ready_o(in_ready),
    .in_data_i(beat_data),
    .out_valid_o(result_valid),
    .out_ready_i(result_ready),
    .out_data_o(result_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Beats waiting to be presented, and results that the model says must come back.
  in_item_t  beats_to_send[$];
  out_item_t pixels_due[$];

  // Idling is switched off for stretches of the run and for its last part.
  bit idling_on = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  // Register mirror, written together with the block's registers.
  logic [DIM_W-1:0]  cfg_width = 9'd256;
  logic [DIM_W-1:0]  cfg_height = 9'd256;
  logic [SEL_W-1:0]  cfg_sel_left = '0;
  logic [SEL_W-1:0]  cfg_sel_top = '0;
  logic [DIM_W-1:0]  cfg_sel_right = 9'd256;
  logic [DIM_W-1:0]  cfg_sel_bottom = 9'd256;
  logic [TURN_W-1:0] cfg_turns = TURN_NONE;

  // Model state of the frame store and the two positions.
  logic [PIX_W-1:0] frame_copy [0:MAX_DIM*MAX_DIM-1];
  int unsigned load_count = 0;
  int unsigned read_index = 0;
  bit          frame_complete = 1'b0;

  // Run statistics for the closing summary.
  int unsigned beats_queued = 0;
  int unsigned loads_taken = 0;
  int unsigned reads_taken = 0;
  int unsigned good_answers = 0;
  int unsigned bad_sel_answers = 0;
  int unsigned unloaded_answers = 0;
  int unsigned settings_written = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;

  // A size register below 1 acts as 1 and one above the maximum acts as the maximum.
  function automatic int unsigned dim_limit(input logic [DIM_W-1:0] raw);
    if (raw == 0) begin
      return 1;
    end
    if (raw > MAX_DIM) begin
      return MAX_DIM;
    end
    return raw;
  endfunction

  // Applies one accepted beat to the model. A load writes the next store entry, restarting
  // the frame when the previous one is complete or the size shrank below the load count.
  // A read produces one expected result: the next pixel of the turned frame, or an error.
  function automatic void predict_rotated_pixel(input in_item_t beat);
    int unsigned wd, ht, total, res_w, y, x, src_r, src_c;
    int unsigned side, ly, lx, ty, tx, l, t, r, b, addr;
    bit          full;
    out_item_t   res;
    wd = dim_limit(cfg_width);
    ht = dim_limit(cfg_height);
    total = wd * ht;
    l = cfg_sel_left;
    t = cfg_sel_top;
    r = cfg_sel_right;
    b = cfg_sel_bottom;
    if (beat.action == ACTION_LOAD) begin
      if (frame_complete || load_count >= total) begin
        load_count = 0;
        read_index = 0;
        frame_complete = 1'b0;
      end
      frame_copy[load_count] = beat.pixel_in;
      load_count++;
      if (load_count == total) begin
        frame_complete = 1'b1;
      end
      loads_taken++;
      return;
    end
    reads_taken++;
    res = '0;
    full = (l == 0) && (t == 0) && (r == wd) && (b == ht);
    if (!frame_complete || load_count != total) begin
      // Nothing loaded yet, a load in progress, or the size changed since the load.
      res.status = STATUS_NOT_LOADED;
      unloaded_answers++;
    end else if (!full && (r <= l || b <= t || r > wd || b > ht || r - l != b - t)) begin
      // A partial selection must be a non-empty square inside the frame.
      res.status = STATUS_SEL_BAD;
      bad_sel_answers++;
    end else begin
      // Odd whole-frame turns swap the frame's width and height.
      res_w = (full && cfg_turns[0]) ? ht : wd;
      if (read_index >= total) begin
        read_index = 0;
      end
      y = read_index / res_w;
      x = read_index % res_w;
      src_r = y;
      src_c = x;
      if (full) begin
        case (cfg_turns)
          TURN_CW90: begin
            src_r = ht - 1 - x;
            src_c = y;
          end
          TURN_HALF: begin
            src_r = ht - 1 - y;
            src_c = wd - 1 - x;
          end
          TURN_CCW90: begin
            src_r = x;
            src_c = wd - 1 - y;
          end
          default: ;
        endcase
      end else if (y >= t && y < b && x >= l && x < r) begin
        // Inside the square the turn works on local coordinates.
        side = r - l;
        ly = y - t;
        lx = x - l;
        ty = ly;
        tx = lx;
        case (cfg_turns)
          TURN_CW90: begin
            ty = side - 1 - lx;
            tx = ly;
          end
          TURN_HALF: begin
            ty = side - 1 - ly;
            tx = side - 1 - lx;
          end
          TURN_CCW90: begin
            ty = lx;
            tx = side - 1 - ly;
          end
          default: ;
        endcase
        src_r = t + ty;
        src_c = l + tx;
      end
      addr = src_r * wd + src_c;
      res.pixel_out = (addr < MAX_DIM * MAX_DIM) ? frame_copy[addr] : '0;
      res.status = STATUS_OK;
      if (read_index == total - 1) begin
        res.out_last = 1'b1;
        read_index = 0;
      end else begin
        read_index++;
      end
      good_answers++;
    end
    pixels_due.push_back(res);
  endfunction

  // 50 MHz-style clock with a period of 20 time units.
  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver. The model sees each beat on the edge that accepts it. A beat that is not yet
  // taken stays on the bus unchanged; otherwise the driver either starts an idle burst,
  // when idling is on, or presents the next queued beat.
  always @(posedge clk) begin : beat_driver
    bit accepted;
    accepted = beat_valid && in_ready;
    if (accepted) begin
      predict_rotated_pixel(beat_data);
    end
    if (!rst_n) begin
      beat_valid <= 1'b0;
    end else if (beat_valid && !accepted) begin
      // Hold the current beat until it is taken.
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      beat_valid <= 1'b0;
    end else if (beats_to_send.size() != 0 && idling_on && $urandom_range(0, 99) < 10) begin
      send_gap <= $urandom_range(0, 8);
      beat_valid <= 1'b0;
    end else if (beats_to_send.size() != 0) begin
      beat_data <= beats_to_send.pop_front();
      beat_valid <= 1'b1;
    end else begin
      beat_valid <= 1'b0;
    end
  end

  // Monitor. Each accepted result beat is checked against the oldest expectation, and the
  // ready line stalls in random bursts while idling is on.
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (pixels_due.size() == 0) begin
          $error("result beat with no read waiting for it: %p", result_data);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          results_checked++;
          if (result_data.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %06h, got %06h", want.pixel_out, result_data.pixel_out);
            mismatches++;
          end
          if (result_data.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, result_data.out_last);
            mismatches++;
          end
          if (result_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_data.status);
            mismatches++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        result_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 99) < 10) begin
        recv_gap <= $urandom_range(0, 8);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // The run is cut off long after the slowest correct run would have ended.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("FAIL quarter_turn_image_rotator_top");
    $finish;
  end

  task automatic queue_load(input logic [PIX_W-1:0] pixel);
    in_item_t beat;
    beat.action = ACTION_LOAD;
    beat.pixel_in = pixel;
    beats_to_send.push_back(beat);
    beats_queued++;
  endtask

  // The pixel field of a read is ignored by the block, so it carries noise.
  task automatic queue_read();
    in_item_t beat;
    beat.action = ACTION_READ;
    beat.pixel_in = PIX_W'($urandom());
    beats_to_send.push_back(beat);
    beats_queued++;
  endtask

  // Returns once every queued beat is taken and every expected result has arrived.
  // Sampling on the falling edge keeps this clear of the driver's updates.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (beats_to_send.size() != 0 || beat_valid || pixels_due.size() != 0);
  endtask

  // One register write: a setup phase, then an access phase that completes on pready.
  // Bits above the field carry noise, since the block keeps only the field.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    logic [APB_DATA_W-1:0] field_mask;
    logic [APB_DATA_W-1:0] word;
    case (idx)
      REG_SEL_LEFT, REG_SEL_TOP: field_mask = 32'h0FF;
      REG_QUARTER_TURNS: field_mask = 32'h003;
      default: field_mask = 32'h1FF;
    endcase
    word = ($urandom() & ~field_mask) | (value & field_mask);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: cfg_width = word[DIM_W-1:0];
      REG_FRAME_HEIGHT: cfg_height = word[DIM_W-1:0];
      REG_SEL_LEFT: cfg_sel_left = word[SEL_W-1:0];
      REG_SEL_TOP: cfg_sel_top = word[SEL_W-1:0];
      REG_SEL_RIGHT: cfg_sel_right = word[DIM_W-1:0];
      REG_SEL_BOTTOM: cfg_sel_bottom = word[DIM_W-1:0];
      REG_QUARTER_TURNS: cfg_turns = word[TURN_W-1:0];
      default: ;
    endcase
  endtask

  // Waits for the block to go quiet (a trailing load may still be in flight after the
  // last result) and then programs a whole setting.
  task automatic program_frame(input int unsigned wd, input int unsigned ht,
                               input int unsigned l, input int unsigned t,
                               input int unsigned r, input int unsigned b,
                               input int unsigned turns);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_FRAME_WIDTH, wd);
    write_reg(REG_FRAME_HEIGHT, ht);
    write_reg(REG_SEL_LEFT, l);
    write_reg(REG_SEL_TOP, t);
    write_reg(REG_SEL_RIGHT, r);
    write_reg(REG_SEL_BOTTOM, b);
    write_reg(REG_QUARTER_TURNS, turns);
    settings_written++;
  endtask

  // One random setting followed by a frame load and a run of reads. Most phases are
  // well formed; some stop loading early, read in the middle of a load, keep the previous
  // frame under a swapped size, or slip a restarting load in among the reads.
  task automatic random_phase(input int unsigned phase_no);
    int unsigned w_reg, h_reg, wd, ht, total, side, l, t, r, b, reads, stop_at, kind;
    bit          reuse;
    reuse = (phase_no > 3) && ($urandom_range(0, 4) == 0);
    if (phase_no == 2) begin
      // Widest frame: one row of 256 pixels.
      w_reg = 256;
      h_reg = 1;
      reuse = 1'b0;
    end else if (phase_no == 3) begin
      // The same 256 pixels seen as one column, through clamped size registers.
      w_reg = 0;
      h_reg = 511;
      reuse = 1'b1;
    end else if (reuse) begin
      w_reg = cfg_height;
      h_reg = cfg_width;
    end else begin
      w_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      h_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    end
    wd = dim_limit(w_reg);
    ht = dim_limit(h_reg);
    total = wd * ht;

    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      l = 0;
      t = 0;
      r = wd;
      b = ht;
    end else if (kind < 7) begin
      side = $urandom_range(1, (wd < ht) ? wd : ht);
      l = $urandom_range(0, wd - side);
      t = $urandom_range(0, ht - side);
      r = l + side;
      b = t + side;
    end else if (kind < 9) begin
      // Near the frame: may be square, non-square, empty or one past the edge.
      l = $urandom_range(0, wd - 1);
      t = $urandom_range(0, ht - 1);
      r = $urandom_range(l, wd + 1);
      b = $urandom_range(t, ht + 1);
    end else begin
      l = $urandom_range(0, 255);
      t = $urandom_range(0, 255);
      r = $urandom_range(0, 511);
      b = $urandom_range(0, 511);
    end
    program_frame(w_reg, h_reg, l, t, r, b, $urandom_range(0, 3));

    if (!reuse) begin
      kind = $urandom_range(0, 9);
      stop_at = (kind == 0) ? $urandom_range(0, total - 1) : total;
      for (int i = 0; i < stop_at; i++) begin
        if (kind == 1 && i == total / 2) begin
          queue_read();
        end
        queue_load(PIX_W'($urandom()));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      wait_drained();
    end

    reads = total + $urandom_range(1, total);
    if (reads > 40) begin
      reads = 40;
    end
    for (int i = 0; i < reads; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        queue_load(PIX_W'($urandom()));
      end else begin
        queue_read();
      end
    end
  endtask

  // Stimulus: a short directed part, then random phases, then the wind-down.
  initial begin : stimulus
    int unsigned phase_no;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end

    // Reset settings with nothing loaded: the read must report a missing frame.
    idling_on = 1'b1;
    queue_read();

    // A 2 by 3 frame turned a quarter clockwise. The pixels carry all-zero, all-one and
    // alternating patterns, and one read too many wraps back past the last pixel.
    program_frame(2, 3, 0, 0, 2, 3, TURN_CW90);
    queue_load(24'h000000);
    queue_load(24'hFFFFFF);
    queue_load(24'hAAAAAA);
    queue_load(24'h555555);
    queue_load(24'h0F0F0F);
    queue_load(24'hF0F0F0);
    repeat (7) queue_read();

    // A partial selection that is not square.
    program_frame(2, 3, 0, 0, 1, 2, TURN_HALF);
    queue_read();

    // The size no longer matches the loaded frame; the selection sits at its extremes.
    program_frame(3, 3, 255, 255, 256, 256, TURN_NONE);
    queue_read();

    // Smaller size again, then a load after a complete frame restarts it. The reads turn
    // a one-pixel square in the corner, which leaves everything in place.
    program_frame(2, 2, 1, 1, 2, 2, TURN_CCW90);
    queue_read();
    repeat (4) queue_load(PIX_W'($urandom()));
    repeat (4) queue_read();

    // Random phases, with some phases free of idling and none in the last stretch.
    phase_no = 0;
    while (beats_queued < TOTAL_BEATS) begin
      idling_on = (phase_no % 5 != 4) && (beats_queued + 150 < TOTAL_BEATS);
      random_phase(phase_no);
      phase_no++;
    end

    idling_on = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d load and %0d read beats over %0d register settings.",
             loads_taken, reads_taken, settings_written);
    $display("Checked %0d results: %0d pixels, %0d bad selections, %0d reads with no frame.",
             results_checked, good_answers, bad_sel_answers, unloaded_answers);
    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("PASS quarter_turn_image_rotator_top");
    end else begin
      $display("FAIL quarter_turn_image_rotator_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
